>>> hw/rtl/spq_pkg.sv
// Shared types and constants of the stable sorted priority queue.
package spq_pkg;

   localparam int DEFAULT_QUEUE_DEPTH = 128;
   localparam int ID_W    = 32;
   localparam int CLASS_W = 2;
   localparam int TIME_W  = 17;
   localparam int KEY_W   = 19;
   localparam int FILL_W  = 8;
   localparam int CLASS_SCALE = 100000;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_POP    = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_INSERTED = 2'd0,
      ST_FULL     = 2'd1,
      ST_POPPED   = 2'd2,
      ST_EMPTY    = 2'd3
   } status_type;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [CLASS_W-1:0] pclass;
      logic [TIME_W-1:0]  time_stamp;
      logic [KEY_W-1:0]   key;
   } entry_type;

   typedef struct packed {
      logic insert_en;
      logic pop_en;
   } cell_ctrl_type;

   function automatic logic [KEY_W-1:0] sort_key(input logic [CLASS_W-1:0] pclass,
                                                 input logic [TIME_W-1:0] time_stamp);
      logic [KEY_W-1:0] scaled;
      scaled = KEY_W'(pclass) * KEY_W'(CLASS_SCALE);
      return scaled + KEY_W'(time_stamp);
   endfunction

endpackage

>>> hw/rtl/spq_cell.sv
// One slot of the sorted shift chain: compares its key and shifts left or right.
module spq_cell
   import spq_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  logic          occupied,
   input  entry_type     new_entry,
   input  entry_type     left_entry,
   input  logic          left_greater,
   input  entry_type     right_entry,
   output entry_type     entry,
   output logic          greater
);

   entry_type entry_ff;
   entry_type entry_in;

   // A held entry with a strictly larger key moves back, so equal keys keep their order.
   assign greater = occupied && (entry_ff.key > new_entry.key);
   assign entry   = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.pop_en) begin
         entry_in = right_entry;
      end else if (ctrl.insert_en) begin
         if (left_greater) begin
            entry_in = left_entry;
         end else if (greater || !occupied) begin
            entry_in = new_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

>>> hw/rtl/stable_priority_queue.sv
// Top level of the stable sorted priority queue: cell chain, fill count and result register.
//
// The queue holds up to QUEUE_DEPTH entries in a row of cells kept sorted by
// priority_class * 100000 + arrival_time, smallest at the head, with equal keys
// leaving in the order they arrived. Every cell compares its key with an incoming
// insert in parallel and the whole row shifts by one place at once, so one request
// (insert or pop) is taken per clock while req_stall is low; its response appears in
// the output register on the next cycle. The single output register means a request is
// stalled only while an unread response sits there under rsp_stall. An insert into
// a full queue returns status 1 and a pop from an empty queue returns status 3;
// both leave the contents unchanged. No start-up clearing is needed after reset.
module stable_priority_queue
   import spq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_opcode,
   input  logic [ID_W-1:0]     req_entry_id,
   input  logic [CLASS_W-1:0]  req_priority_class,
   input  logic [TIME_W-1:0]   req_arrival_time,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_status,
   output logic [ID_W-1:0]     rsp_head_id,
   output logic [CLASS_W-1:0]  rsp_head_priority,
   output logic [TIME_W-1:0]   rsp_head_time,
   output logic [FILL_W-1:0]   rsp_fill_level
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   status_type       status_ff;
   status_type       status_in;
   entry_type        head_ff;
   entry_type        head_in;
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;

   logic          accept;
   logic          is_full;
   logic          is_empty;
   opcode_type    opcode;
   entry_type     new_entry;
   cell_ctrl_type ctrl;

   entry_type cell_entry   [QUEUE_DEPTH];
   logic      cell_greater [QUEUE_DEPTH];

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign opcode    = opcode_type'(req_opcode);
   assign is_full   = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign is_empty  = (count_ff == '0);

   assign new_entry.id         = req_entry_id;
   assign new_entry.pclass     = req_priority_class;
   assign new_entry.time_stamp = req_arrival_time;
   assign new_entry.key        = sort_key(req_priority_class, req_arrival_time);

   assign ctrl.insert_en = accept && (opcode == OP_INSERT) && !is_full;
   assign ctrl.pop_en    = accept && (opcode == OP_POP) && !is_empty;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      entry_type left_entry;
      entry_type right_entry;
      logic      left_greater;

      if (i == 0) begin : g_first
         assign left_entry   = new_entry;
         assign left_greater = 1'b0;
      end else begin : g_inner
         assign left_entry   = cell_entry[i-1];
         assign left_greater = cell_greater[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign right_entry = cell_entry[i];
      end else begin : g_mid
         assign right_entry = cell_entry[i+1];
      end

      spq_cell u_cell (
         .clock        (clock),
         .ctrl         (ctrl),
         .occupied     (CNT_W'(i) < count_ff),
         .new_entry    (new_entry),
         .left_entry   (left_entry),
         .left_greater (left_greater),
         .right_entry  (right_entry),
         .entry        (cell_entry[i]),
         .greater      (cell_greater[i])
      );
   end

   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      status_in    = status_ff;
      head_in      = head_ff;
      if (ctrl.insert_en) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.pop_en) begin
         count_in = count_ff - CNT_W'(1);
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         head_in      = '0;
         unique case (opcode)
            OP_INSERT: status_in = is_full ? ST_FULL : ST_INSERTED;
            OP_POP: begin
               if (is_empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  status_in = ST_POPPED;
                  head_in   = cell_entry[0];
               end
            end
            default: status_in = ST_EMPTY;
         endcase
      end
      fill_in = accept ? FILL_W'(count_in) : fill_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      head_ff   <= head_in;
      fill_ff   <= fill_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_head_id       = head_ff.id;
   assign rsp_head_priority = head_ff.pclass;
   assign rsp_head_time     = head_ff.time_stamp;
   assign rsp_fill_level    = fill_ff;

endmodule

>>> test/stable_priority_queue_test.sv
// Self-checking testbench for the stable sorted priority queue.
`timescale 1ns / 1ps

module stable_priority_queue_test;
   import spq_pkg::*;

   localparam int QUEUE_DEPTH   = DEFAULT_QUEUE_DEPTH;
   localparam int WATCHDOG_MAX  = 3000;
   localparam int HOLD_AT       = 450;
   localparam int HOLD_CYCLES   = 60;
   localparam int TAIL_REQUESTS = 80;
   localparam int TARGET_ITEMS  = 800;
   localparam int ROUND_ITEMS   = 360;

   typedef struct {
      opcode_type          opcode;
      logic [ID_W-1:0]     entry_id;
      logic [CLASS_W-1:0]  pclass;
      logic [TIME_W-1:0]   tstamp;
      bit                  pause;
   } queue_request_type;

   typedef struct {
      logic [ID_W-1:0]     entry_id;
      logic [CLASS_W-1:0]  pclass;
      logic [TIME_W-1:0]   tstamp;
   } held_entry_type;

   typedef struct {
      status_type          status;
      logic [ID_W-1:0]     head_id;
      logic [CLASS_W-1:0]  head_class;
      logic [TIME_W-1:0]   head_tstamp;
      logic [FILL_W-1:0]   fill;
   } queue_response_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_opcode = 1'b0;
   logic [ID_W-1:0]    req_entry_id = '0;
   logic [CLASS_W-1:0] req_priority_class = '0;
   logic [TIME_W-1:0]  req_arrival_time = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_status;
   logic [ID_W-1:0]    rsp_head_id;
   logic [CLASS_W-1:0] rsp_head_priority;
   logic [TIME_W-1:0]  rsp_head_time;
   logic [FILL_W-1:0]  rsp_fill_level;

   queue_request_type  request_backlog[$];
   queue_response_type expected_responses[$];
   held_entry_type     sorted_entries[$];

   int sent_count = 0;
   int got_count = 0;
   int mismatches = 0;
   int n_inserted = 0;
   int n_dropped = 0;
   int n_popped = 0;
   int n_empty = 0;
   int gen_fill = 0;
   int idle_cycles = 0;

   int  gap_left = 0;
   int  send_calm_left = 0;
   int  stall_left = 0;
   int  recv_calm_left = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;
   logic calm_tail = 1'b0;
   logic long_hold = 1'b0;

   stable_priority_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_entry_id       (req_entry_id),
      .req_priority_class (req_priority_class),
      .req_arrival_time   (req_arrival_time),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_head_id        (rsp_head_id),
      .rsp_head_priority  (rsp_head_priority),
      .rsp_head_time      (rsp_head_time),
      .rsp_fill_level     (rsp_fill_level)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int unsigned entry_rank(logic [CLASS_W-1:0] pc, logic [TIME_W-1:0] ts);
      return 32'(pc) * CLASS_SCALE + 32'(ts);
   endfunction

   // Applies one request to the sorted copy and returns the response it should give.
   function automatic queue_response_type predict_queue_op(queue_request_type r);
      queue_response_type res;
      held_entry_type     e;
      int                 pos;
      int unsigned        rank;
      res.status      = ST_INSERTED;
      res.head_id     = '0;
      res.head_class  = '0;
      res.head_tstamp = '0;
      if (r.opcode == OP_INSERT) begin
         if (sorted_entries.size() >= QUEUE_DEPTH) begin
            res.status = ST_FULL;
            n_dropped++;
         end else begin
            rank = entry_rank(r.pclass, r.tstamp);
            pos = sorted_entries.size();
            // Equal ranks stay ahead of the newcomer, which keeps ties in arrival order.
            while (pos > 0 && entry_rank(sorted_entries[pos-1].pclass,
                                         sorted_entries[pos-1].tstamp) > rank)
               pos--;
            e.entry_id = r.entry_id;
            e.pclass   = r.pclass;
            e.tstamp   = r.tstamp;
            sorted_entries.insert(pos, e);
            n_inserted++;
         end
      end else if (sorted_entries.size() == 0) begin
         res.status = ST_EMPTY;
         n_empty++;
      end else begin
         e = sorted_entries.pop_front();
         res.status      = ST_POPPED;
         res.head_id     = e.entry_id;
         res.head_class  = e.pclass;
         res.head_tstamp = e.tstamp;
         n_popped++;
      end
      res.fill = FILL_W'(sorted_entries.size());
      return res;
   endfunction

   task automatic add_request(opcode_type op, logic [ID_W-1:0] id, logic [CLASS_W-1:0] pc,
                              logic [TIME_W-1:0] ts);
      queue_request_type r;
      r.opcode   = op;
      r.entry_id = id;
      r.pclass   = pc;
      r.tstamp   = ts;
      r.pause    = 1'b0;
      request_backlog.push_back(r);
      if (op == OP_INSERT && gen_fill < QUEUE_DEPTH)
         gen_fill++;
      else if (op == OP_POP && gen_fill > 0)
         gen_fill--;
   endtask

   task automatic add_pause();
      queue_request_type r;
      r.opcode   = OP_POP;
      r.entry_id = '0;
      r.pclass   = '0;
      r.tstamp   = '0;
      r.pause    = 1'b1;
      request_backlog.push_back(r);
   endtask

   function automatic logic [CLASS_W-1:0] pick_class();
      return ($urandom_range(0, 9) == 0) ? CLASS_W'(0) : CLASS_W'($urandom_range(1, 3));
   endfunction

   function automatic logic [TIME_W-1:0] pick_tstamp();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return TIME_W'(99999);
         2: return TIME_W'($urandom_range(100000, 131071));
         default: return TIME_W'($urandom_range(0, 99999));
      endcase
   endfunction

   task automatic add_random_insert();
      add_request(OP_INSERT, $urandom, pick_class(), pick_tstamp());
   endtask

   // Requests are taken from the backlog; a pause marker holds the sender until all
   // outstanding responses are back.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         calm_tail <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_responses.push_back(predict_queue_op('{opcode_type'(req_opcode),
               req_entry_id, req_priority_class, req_arrival_time, 1'b0}));
            sent_count++;
         end
         if (req_valid && req_stall) begin
            req_valid <= 1'b1;
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (request_backlog.size() == 0) begin
            req_valid <= 1'b0;
         end else if (request_backlog[0].pause) begin
            req_valid <= 1'b0;
            if (sent_count == got_count)
               void'(request_backlog.pop_front());
         end else if (!calm_tail && !long_hold && send_calm_left == 0 &&
                      $urandom_range(0, 7) == 0) begin
            gap_left = $urandom_range(0, 13);
            req_valid <= 1'b0;
         end else begin
            queue_request_type r;
            r = request_backlog.pop_front();
            req_valid          <= 1'b1;
            req_opcode         <= r.opcode;
            req_entry_id       <= r.entry_id;
            req_priority_class <= r.pclass;
            req_arrival_time   <= r.tstamp;
            if (send_calm_left > 0)
               send_calm_left--;
            else if ($urandom_range(0, 39) == 0)
               send_calm_left = $urandom_range(20, 80);
         end
         calm_tail <= (request_backlog.size() <= TAIL_REQUESTS);
      end
   end

   task automatic check_field(input string label, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s expected %0h, got %0h", $time, label, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         long_hold <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_responses.size() == 0) begin
               mismatches++;
               $display("%0t: no response expected, got status %0d id %0h", $time,
                        rsp_status, rsp_head_id);
            end else begin
               queue_response_type want;
               want = expected_responses.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_status));
               check_field("head_id", want.head_id, rsp_head_id);
               check_field("head_priority", 32'(want.head_class), 32'(rsp_head_priority));
               check_field("head_time", 32'(want.head_tstamp), 32'(rsp_head_time));
               check_field("fill_level", 32'(want.fill), 32'(rsp_fill_level));
            end
            got_count <= got_count + 1;
         end
         // One long hold-off lets the single output register back up into the input.
         if (!hold_done && got_count == HOLD_AT) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!calm_tail && recv_calm_left == 0 && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 13);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            if (recv_calm_left > 0)
               recv_calm_left--;
            else if ($urandom_range(0, 39) == 0)
               recv_calm_left = $urandom_range(20, 80);
         end
         long_hold <= (hold_left > 0);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_MAX) begin
         $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
         $display("FAILED: results differ");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      // Directed part: empty pop, field extremes, class zero, over-range times and ties.
      add_request(OP_POP, '0, '0, '0);
      add_request(OP_INSERT, 32'hFFFF_FFFF, 2'd3, TIME_W'(99999));
      add_request(OP_INSERT, 32'h0000_0000, 2'd1, TIME_W'(0));
      add_request(OP_INSERT, 32'hA5A5_A5A5, 2'd0, TIME_W'(5));
      add_request(OP_INSERT, 32'h5A5A_5A5A, 2'd2, TIME_W'(131071));
      add_request(OP_INSERT, 32'h0000_0001, 2'd3, TIME_W'(0));
      add_request(OP_INSERT, 32'h0000_0002, 2'd1, TIME_W'(0));
      add_request(OP_INSERT, 32'h0000_0003, 2'd1, TIME_W'(100000));
      add_request(OP_INSERT, 32'h0000_0004, 2'd2, TIME_W'(0));
      repeat (9)
         add_request(OP_POP, '0, '0, '0);
      add_pause();

      // A whole round adds roughly ROUND_ITEMS requests, so stop before overshooting.
      while (request_backlog.size() + ROUND_ITEMS <= TARGET_ITEMS) begin
         int n;
         repeat (60) begin
            if ($urandom_range(0, 1) == 0)
               add_random_insert();
            else
               add_request(OP_POP, $urandom, pick_class(), pick_tstamp());
         end
         // Fill to the top and a little past it so that inserts are dropped.
         n = QUEUE_DEPTH - gen_fill + $urandom_range(2, 6);
         repeat (n)
            add_random_insert();
         n = gen_fill + $urandom_range(1, 4);
         repeat (n)
            add_request(OP_POP, $urandom, pick_class(), pick_tstamp());
         add_pause();
         // Narrow keys give many equal ranks.
         repeat (40) begin
            if ($urandom_range(0, 2) == 0)
               add_request(OP_POP, '0, '0, '0);
            else
               add_request(OP_INSERT, $urandom, CLASS_W'($urandom_range(1, 2)),
                           TIME_W'($urandom_range(0, 3)));
         end
      end

      while (request_backlog.size() < TARGET_ITEMS) begin
         if ($urandom_range(0, 1) == 0)
            add_random_insert();
         else
            add_request(OP_POP, $urandom, pick_class(), pick_tstamp());
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (request_backlog.size() != 0 || req_valid || sent_count != got_count)
         @(negedge clock);
      repeat (8) @(negedge clock);
      if (expected_responses.size() != 0) begin
         mismatches++;
         $display("%0t: %0d responses expected, none arrived", $time,
                  expected_responses.size());
      end

      $display("Run covered %0d requests: %0d inserted, %0d dropped while full,",
               sent_count, n_inserted, n_dropped);
      $display("%0d popped and %0d pops on an empty queue.", n_popped, n_empty);
      if (mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
